### rtl/fbfla_pkg.sv
// ----------------------------------------------------------------------------
// fbfla_pkg
// Types, constants and codes for the fixed-size block free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fbfla_pkg;

    localparam int MAX_BLOCKS   = 1024;
    localparam int WORD_BYTES   = 8;
    localparam int HEADER_WORDS = 3;

    localparam int IDX_W    = $clog2(MAX_BLOCKS);
    localparam int CNT_W    = IDX_W + 1;
    localparam int SIZE_W   = 13;
    localparam int OFS_W    = 22;
    localparam int WSHIFT   = $clog2(WORD_BYTES);
    localparam int WORDS_W  = SIZE_W - WSHIFT + 1;
    localparam int PROD_W   = IDX_W + WORDS_W;
    localparam int HDR_BYTES = HEADER_WORDS * WORD_BYTES;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SIZE_W;

    typedef logic [1:0] t_mode;
    typedef logic [1:0] t_status;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_mode MODE_INIT  = 2'd0;
    localparam t_mode MODE_ALLOC = 2'd1;
    localparam t_mode MODE_FREE  = 2'd2;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_NO_BLOCK = 2'd1;
    localparam t_status ST_REFUSED  = 2'd2;

    localparam t_cfg_idx CFG_BLOCK_COUNT = 2'd0;
    localparam t_cfg_idx CFG_BLOCK_BYTES = 2'd1;

    localparam logic [CNT_W-1:0]  RST_BLOCK_COUNT = CNT_W'(1);
    localparam logic [SIZE_W-1:0] RST_BLOCK_BYTES = SIZE_W'(8);

    typedef struct packed {
        t_mode            mode;
        logic [IDX_W-1:0] block_index;
    } t_cmd;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] given_index;
        logic [OFS_W-1:0] given_offset;
        logic [CNT_W-1:0] free_count;
    } t_res;

endpackage

`default_nettype wire

### rtl/fixed_block_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_core
// Free-list allocator for fixed-size blocks; next-block links held in a
// synchronous memory with one write and one read port, head and free count
// in registers.
// ----------------------------------------------------------------------------
//  channel   signals                                   transfer
//  command   start, busy, i_cmd                        start && !busy
//  result    o_done, o_res                             o_done, one cycle
//  config    i_cfg_valid, o_cfg_ready, i_cfg_index,    i_cfg_valid && o_cfg_ready
//            i_cfg_data
//
//  alloc: result registered from the S_ALLOC state (one link memory read)
//  free, refused ops, mode 3, init with zero blocks: result in the cycle after
//  init: n link writes, one per cycle, result registered with the last write
//  busy is high while an alloc or an init is in progress
//  o_done lasts one cycle; the receiver cannot hold results off
//  synchronous active-low reset; link memory holds no reset value
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_free_list_allocator_core
    import fbfla_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output      logic                  busy,
    input  wire t_cmd                  i_cmd,
    output      logic                  o_done,
    output      t_res                  o_res,
    input  wire logic                  i_cfg_valid,
    output      logic                  o_cfg_ready,
    input  wire t_cfg_idx              i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_INIT  = 2'd1;
    localparam logic [1:0] S_ALLOC = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]  r_free, n_free;
    logic [IDX_W-1:0]  r_fill, n_fill;
    logic              r_done, n_done;
    t_res              r_res, n_res;
    logic [CNT_W-1:0]  r_block_count;
    logic [SIZE_W-1:0] r_block_bytes;
    logic [PROD_W-1:0] r_prod;
    logic [IDX_W-1:0]  r_rdata;

    logic [IDX_W-1:0]  link_mem [MAX_BLOCKS];

    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    logic [IDX_W-1:0]  w_wdata;
    logic [CNT_W-1:0]  w_count;
    logic [WORDS_W-1:0] w_words;
    logic [OFS_W-1:0]  w_offset;

    // effective block count, limited to the memory depth
    assign w_count = (r_block_count > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                          : r_block_count;
    // block size in words, rounded up
    assign w_words = WORDS_W'(({1'b0, r_block_bytes} + (SIZE_W+1)'(WORD_BYTES - 1)) >> WSHIFT);
    assign w_offset = OFS_W'(HDR_BYTES) + OFS_W'({r_prod, WSHIFT'(0)});

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_free  = r_free;
        n_fill  = r_fill;
        n_done  = 1'b0;
        n_res   = r_res;
        w_we    = 1'b0;
        w_waddr = r_fill;
        w_wdata = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_res.status       = ST_OK;
                    n_res.given_index  = '0;
                    n_res.given_offset = '0;
                    n_res.free_count   = r_free;
                    case (i_cmd.mode)
                        MODE_INIT: begin
                            if (w_count == '0) begin
                                n_head           = '0;
                                n_free           = '0;
                                n_res.free_count = '0;
                                n_done           = 1'b1;
                            end else begin
                                n_fill  = '0;
                                n_state = S_INIT;
                            end
                        end
                        MODE_ALLOC: begin
                            if (r_free == '0) begin
                                n_res.status = ST_NO_BLOCK;
                                n_done       = 1'b1;
                            end else begin
                                n_state = S_ALLOC;
                            end
                        end
                        MODE_FREE: begin
                            if (r_free >= w_count) begin
                                n_res.status = ST_REFUSED;
                            end else begin
                                w_we             = 1'b1;
                                w_waddr          = i_cmd.block_index;
                                w_wdata          = r_head;
                                n_head           = i_cmd.block_index;
                                n_free           = r_free + CNT_W'(1);
                                n_res.free_count = r_free + CNT_W'(1);
                            end
                            n_done = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_INIT: begin
                w_we    = 1'b1;
                w_waddr = r_fill;
                if ({1'b0, r_fill} == w_count - CNT_W'(1)) begin
                    w_wdata          = '0;
                    n_head           = '0;
                    n_free           = w_count;
                    n_res.free_count = w_count;
                    n_done           = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    w_wdata = r_fill + IDX_W'(1);
                    n_fill  = r_fill + IDX_W'(1);
                end
            end
            S_ALLOC: begin
                n_head             = r_rdata;
                n_free             = r_free - CNT_W'(1);
                n_res.status       = ST_OK;
                n_res.given_index  = r_head;
                n_res.given_offset = w_offset;
                n_res.free_count   = r_free - CNT_W'(1);
                n_done             = 1'b1;
                n_state            = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            link_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= link_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(r_head) * PROD_W'(w_words);
        r_res  <= n_res;
        r_fill <= n_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_head        <= '0;
            r_free        <= '0;
            r_done        <= 1'b0;
            r_block_count <= RST_BLOCK_COUNT;
            r_block_bytes <= RST_BLOCK_BYTES;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_free  <= n_free;
            r_done  <= n_done;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_BLOCK_COUNT: r_block_count <= i_cfg_data[CNT_W-1:0];
                    CFG_BLOCK_BYTES: r_block_bytes <= i_cfg_data[SIZE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

### rtl/fbfla_checker.sv
// ----------------------------------------------------------------------------
// fbfla_checker
// Port-level checks for the block allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fbfla_checker
    import fbfla_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  start,
    input wire logic                  busy,
    input wire t_cmd                  i_cmd,
    input wire logic                  o_done,
    input wire t_res                  o_res
);

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("transfer without progress");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result while still busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res.free_count <= CNT_W'(MAX_BLOCKS)))
        else $error("free count out of range");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status != ST_OK) |->
            (o_res.given_index == '0 && o_res.given_offset == '0))
        else $error("failed op returned a block");

    a_no_block_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status == ST_NO_BLOCK) |-> (o_res.free_count == '0))
        else $error("no block reported with free blocks left");

endmodule

bind fixed_block_free_list_allocator_core fbfla_checker u_fbfla_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_cmd   (i_cmd),
    .o_done  (o_done),
    .o_res   (o_res)
);

`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fixed-size block free-list allocator. Commands
// go in through the start/busy port with random hold-off. Every transfer is
// run through a cycle-free model of the free list, and each o_done result is
// compared field by field against the oldest prediction. Directed checks
// cover reset defaults, every mode, an empty list, a full list, a lowered
// count, zero and maximum block size and offset wrap. Random phases then
// reprogram the registers and run alloc/free traffic. Most frees return
// blocks that are currently allocated, the rest use random indexes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
    import fbfla_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam t_mode MODE_SPARE = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_cmd                  i_cmd;
    logic                  o_done;
    t_res                  o_res;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    t_cfg_idx              i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    logic [IDX_W-1:0]  link_mem [MAX_BLOCKS];
    logic [IDX_W-1:0]  top_idx;
    logic [CNT_W-1:0]  free_cnt;
    logic [CNT_W-1:0]  cfg_count;
    logic [SIZE_W-1:0] cfg_bytes;

    t_res pending_results [$];
    t_res last_pred;
    int   n_err;
    bit   burst;

    fixed_block_free_list_allocator_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic int managed_blocks();
        return (int'(cfg_count) > MAX_BLOCKS) ? MAX_BLOCKS : int'(cfg_count);
    endfunction

    function automatic t_res predict_result(input t_cmd c);
        t_res r;
        int   lim;
        int   blk;
        r   = '0;
        lim = managed_blocks();
        blk = ((int'(cfg_bytes) + WORD_BYTES - 1) / WORD_BYTES) * WORD_BYTES;
        case (c.mode)
            MODE_INIT: begin
                for (int i = 0; i < lim; i++)
                    link_mem[i] = (i + 1 < lim) ? IDX_W'(i + 1) : '0;
                top_idx  = '0;
                free_cnt = CNT_W'(lim);
            end
            MODE_ALLOC: begin
                if (free_cnt == '0) begin
                    r.status = ST_NO_BLOCK;
                end else begin
                    r.given_index  = top_idx;
                    r.given_offset = OFS_W'(HDR_BYTES + int'(top_idx) * blk);
                    top_idx        = link_mem[top_idx];
                    free_cnt       = free_cnt - CNT_W'(1);
                end
            end
            MODE_FREE: begin
                if (int'(free_cnt) >= lim) begin
                    r.status = ST_REFUSED;
                end else begin
                    link_mem[c.block_index] = top_idx;
                    top_idx  = c.block_index;
                    free_cnt = free_cnt + CNT_W'(1);
                end
            end
            default: ;
        endcase
        r.free_count = free_cnt;
        return r;
    endfunction

    task automatic log_error(input string msg);
        n_err++;
        if (n_err <= 10)
            $display("%0t ns: %s", $realtime, msg);
    endtask

    task automatic send_cmd(input t_mode m, input logic [IDX_W-1:0] idx);
        int   hold_off;
        t_cmd c;
        hold_off      = burst ? 0 : $urandom_range(0, 12);
        c.mode        = m;
        c.block_index = idx;
        if (hold_off > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (hold_off - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= c;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        last_pred = predict_result(c);
        pending_results.push_back(last_pred);
    endtask

    // register writes only once every outstanding result is back
    task automatic write_cfg(input t_cfg_idx a, input logic [CFG_DATA_W-1:0] d);
        int hold_off;
        hold_off = burst ? 0 : $urandom_range(0, 12);
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (hold_off) @(negedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= a;
        i_cfg_data  <= d;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        if (a == CFG_BLOCK_COUNT)
            cfg_count = d[CNT_W-1:0];
        else
            cfg_bytes = d[SIZE_W-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                log_error($sformatf("unexpected result %h", o_res));
            end else begin
                want = pending_results.pop_front();
                if (o_res.status !== want.status || o_res.given_index !== want.given_index
                    || o_res.given_offset !== want.given_offset
                    || o_res.free_count !== want.free_count)
                    log_error($sformatf(
                        "exp/act status %0d/%0d index %0d/%0d offset %0d/%0d count %0d/%0d",
                        want.status, o_res.status, want.given_index, o_res.given_index,
                        want.given_offset, o_res.given_offset,
                        want.free_count, o_res.free_count));
            end
        end
    end

    // reset values: one block of 8 bytes, empty list
    task automatic test_reset_state();
        burst = 1'b1;
        send_cmd(MODE_ALLOC, '0);
        send_cmd(MODE_SPARE, '1);
        send_cmd(MODE_FREE, '1);
        send_cmd(MODE_FREE, '0);
        send_cmd(MODE_ALLOC, '0);
        burst = 1'b0;
    endtask

    task automatic test_operations();
        write_cfg(CFG_BLOCK_COUNT, CFG_DATA_W'(4));
        write_cfg(CFG_BLOCK_BYTES, CFG_DATA_W'(1));
        send_cmd(MODE_INIT, '0);
        repeat (5) send_cmd(MODE_ALLOC, '0);
        send_cmd(MODE_FREE, IDX_W'(2));
        send_cmd(MODE_FREE, '1);
        send_cmd(MODE_ALLOC, '0);
        send_cmd(MODE_ALLOC, '0);
        // count lowered below the number of frees
        write_cfg(CFG_BLOCK_COUNT, CFG_DATA_W'(2));
        send_cmd(MODE_FREE, IDX_W'(3));
        send_cmd(MODE_FREE, IDX_W'(1));
        send_cmd(MODE_FREE, '0);
    endtask

    task automatic test_corner_config();
        write_cfg(CFG_BLOCK_COUNT, CFG_DATA_W'(3));
        write_cfg(CFG_BLOCK_BYTES, '0);
        send_cmd(MODE_INIT, '0);
        send_cmd(MODE_ALLOC, '0);
        send_cmd(MODE_ALLOC, '0);
        write_cfg(CFG_BLOCK_COUNT, '0);
        send_cmd(MODE_INIT, '0);
        send_cmd(MODE_ALLOC, '0);
        send_cmd(MODE_FREE, '0);
        // count above the maximum, largest size, offset wrap
        write_cfg(CFG_BLOCK_COUNT, CFG_DATA_W'(2047));
        write_cfg(CFG_BLOCK_BYTES, CFG_DATA_W'(8191));
        send_cmd(MODE_INIT, '0);
        send_cmd(MODE_ALLOC, '0);
        send_cmd(MODE_FREE, '1);
        send_cmd(MODE_ALLOC, '0);
    endtask

    task automatic test_random_traffic();
        logic [IDX_W-1:0] held [$];
        logic [IDX_W-1:0] idx;
        t_mode            m;
        int               roll;
        int               pick;
        int               lim;
        for (int ph = 0; ph < 8; ph++) begin
            burst = ($urandom_range(0, 3) == 0);
            roll  = $urandom_range(0, 7);
            write_cfg(CFG_BLOCK_COUNT, (roll == 0) ? CFG_DATA_W'($urandom_range(1024, 2047))
                                                   : CFG_DATA_W'($urandom_range(1, 16)));
            roll = $urandom_range(0, 3);
            write_cfg(CFG_BLOCK_BYTES, (roll == 0) ? CFG_DATA_W'(8191) :
                                       (roll == 1) ? CFG_DATA_W'($urandom_range(0, 8191))
                                                   : CFG_DATA_W'($urandom_range(1, 64)));
            if ($urandom_range(0, 7) != 0) begin
                send_cmd(MODE_INIT, IDX_W'($urandom));
                held.delete();
            end
            for (int k = 0; k < 50; k++) begin
                roll = $urandom_range(0, 99);
                idx  = IDX_W'($urandom);
                lim  = managed_blocks();
                if (roll < 4)
                    m = MODE_INIT;
                else if (roll < 50)
                    m = MODE_ALLOC;
                else if (roll < 96)
                    m = MODE_FREE;
                else
                    m = MODE_SPARE;
                if (m == MODE_FREE && held.size() != 0 && $urandom_range(0, 9) < 7) begin
                    pick = $urandom_range(0, held.size() - 1);
                    idx  = held[pick];
                    held.delete(pick);
                end else if (m == MODE_FREE && lim > 0 && $urandom_range(0, 1) == 0) begin
                    idx = IDX_W'($urandom_range(0, lim - 1));
                end
                send_cmd(m, idx);
                if (m == MODE_INIT)
                    held.delete();
                else if (m == MODE_ALLOC && last_pred.status == ST_OK)
                    held.push_back(last_pred.given_index);
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_BLOCK_COUNT;
        i_cfg_data  = '0;
        n_err       = 0;
        burst       = 1'b0;
        last_pred   = '0;
        for (int i = 0; i < MAX_BLOCKS; i++) link_mem[i] = '0;
        top_idx   = '0;
        free_cnt  = '0;
        cfg_count = RST_BLOCK_COUNT;
        cfg_bytes = RST_BLOCK_BYTES;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_operations();
        test_corner_config();
        test_random_traffic();

        @(negedge i_clk);
        start <= 1'b0;
        for (int k = 0; k < 5000 && pending_results.size() != 0; k++) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        n_err += pending_results.size();
        if (n_err == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // every item a full-depth init under the longest hold-off stays well inside
    initial begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

### fixed_block_free_list_allocator_core.f
rtl/fbfla_pkg.sv
rtl/fixed_block_free_list_allocator_core.sv
rtl/fbfla_checker.sv
sim/tb.sv
